/* src/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8dec_pkg;

    localparam int ByteWidth = 8;
    localparam int CpWidth   = 21;

    typedef logic [ByteWidth-1:0] byte_t;
    typedef logic [CpWidth-1:0]   cp_t;

    localparam cp_t ReplacementChar = 21'h00FFFD;

    // Decoder state carried from item to item.
    typedef struct packed {
        logic [1:0] pending;
        cp_t        partial;
        logic       err;
    } dec_state_t;

    // Result of one decode step.
    typedef struct packed {
        logic emit;
        cp_t  code_point;
        logic bad;
        logic final_flag;
        logic ok;
    } dec_result_t;

endpackage

`default_nettype wire

/* src/u8dec_step.sv */
// One-byte UTF-8 decode step: next state and optional result.
`default_nettype none

module u8dec_step (
    input  u8dec_pkg::dec_state_t  cur_state,
    input  u8dec_pkg::byte_t       data_byte,
    input  logic                   buffer_end,
    output u8dec_pkg::dec_state_t  next_state,
    output u8dec_pkg::dec_result_t result
);
    import u8dec_pkg::*;

    dec_state_t st;
    logic       emit;
    logic       bad;
    cp_t        cp;
    cp_t        shifted;

    assign shifted = {cur_state.partial[CpWidth-7:0], data_byte[5:0]};

    always_comb begin
        st   = cur_state;
        emit = 1'b0;
        bad  = 1'b0;
        cp   = '0;

        if (cur_state.pending == 2'd0) begin
            if (data_byte inside {[8'h00:8'h7F]}) begin
                cp   = cp_t'(data_byte);
                emit = 1'b1;
            end else if (data_byte inside {[8'hC0:8'hDF]}) begin
                st.partial = cp_t'(data_byte[4:0]);
                st.pending = 2'd1;
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
                st.partial = cp_t'(data_byte[3:0]);
                st.pending = 2'd2;
            end else if (data_byte inside {[8'hF0:8'hF7]}) begin
                st.partial = cp_t'(data_byte[2:0]);
                st.pending = 2'd3;
            end else begin
                bad  = 1'b1;
                emit = 1'b1;
            end
        end else begin
            if (data_byte inside {[8'h80:8'hBF]}) begin
                st.pending = cur_state.pending - 2'd1;
                if (cur_state.pending == 2'd1) begin
                    cp         = shifted;
                    st.partial = '0;
                    emit       = 1'b1;
                end else begin
                    st.partial = shifted;
                end
            end else begin
                bad        = 1'b1;
                emit       = 1'b1;
                st.pending = 2'd0;
                st.partial = '0;
            end
        end

        // buffer ends inside a sequence
        if (buffer_end && !emit) begin
            bad  = 1'b1;
            emit = 1'b1;
        end

        if (bad) begin
            cp     = ReplacementChar;
            st.err = 1'b1;
        end

        result.emit       = emit;
        result.code_point = cp;
        result.bad        = bad;
        result.final_flag = buffer_end;
        result.ok         = buffer_end && !st.err;

        next_state = buffer_end ? dec_state_t'('0) : st;
    end

endmodule

`default_nettype wire

/* src/utf8_stream_decoder.sv */
// UTF-8 stream decoder top level: input register, decode step, result register.
//
//   channel   dir  tdata                        tuser                       tlast
//   s_axis    in   [7:0] data_byte              -                           buffer_end
//   m_axis    out  [20:0] code_point, zero pad  [0] bad_sequence [1] ok     final_result
//
// One byte per cycle unless m_axis stalls; bytes pass input then result register.
// The decode step is a single combinational pass between the input and result registers.
// Synchronous active-low reset clears valids and decoder state.
// A stalled result holds the input register, so s_axis_tready drops while both are full.
// m_axis_tready reaches s_axis_tready combinationally.
`default_nettype none

module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] bad_sequence, [1] buffer_ok
    output logic        m_axis_tlast    // final_result
);
    import u8dec_pkg::*;

    logic        in_valid_reg, in_valid_next;
    byte_t       in_byte_reg;
    logic        in_last_reg;
    dec_state_t  state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    cp_t         m_cp_reg;
    logic        m_bad_reg;
    logic        m_last_reg;
    logic        m_ok_reg;

    logic        out_free;
    logic        step_fire;
    logic        in_fire;
    dec_result_t res;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign step_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    u8dec_step u_step (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .buffer_end (in_last_reg),
        .next_state (state_next),
        .result     (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (step_fire) begin
            m_valid_next = res.emit;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step_fire && res.emit) begin
            m_cp_reg   <= res.code_point;
            m_bad_reg  <= res.bad;
            m_last_reg <= res.final_flag;
            m_ok_reg   <= res.ok;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_cp_reg};
    assign m_axis_tuser  = {m_ok_reg, m_bad_reg};
    assign m_axis_tlast  = m_last_reg;

    a_bad_is_replacement: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bad_reg |-> m_cp_reg == ReplacementChar)
        else $error("bad item without replacement code point");

    a_ok_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ok_reg |-> m_last_reg && !m_bad_reg)
        else $error("buffer ok on non-final or bad item");

    a_final_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_last_reg |=> state_reg == dec_state_t'('0))
        else $error("state not cleared after buffer end");

    a_final_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_last_reg |=> m_valid_reg && m_last_reg)
        else $error("buffer end produced no final item");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte buffers.
`timescale 1ns / 1ps

module testbench;
    import u8dec_pkg::*;

    class utf8_decode_tracker;
        typedef struct {
            cp_t  code_point;
            logic bad;
            logic fin;
            logic ok;
        } decoded_t;

        decoded_t   awaited_points[$];
        logic [1:0] cont_left;
        cp_t        gathered;
        logic       buf_error;
        int         mismatches;
        int         bytes_seen;
        int         points_seen;
        int         bad_seen;
        int         buffers_seen;

        function new();
            cont_left    = '0;
            gathered     = '0;
            buf_error    = 1'b0;
            mismatches   = 0;
            bytes_seen   = 0;
            points_seen  = 0;
            bad_seen     = 0;
            buffers_seen = 0;
        endfunction

        // Decode one accepted byte and queue the result it causes, if any.
        function void take_byte(byte_t b, logic last);
            decoded_t d;
            logic     emit;
            logic     bad;
            cp_t      cp;
            emit = 1'b0;
            bad  = 1'b0;
            cp   = '0;
            bytes_seen++;
            if (cont_left == 2'd0) begin
                if (b[7] == 1'b0) begin
                    cp   = {13'b0, b};
                    emit = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    gathered  = {16'b0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    gathered  = {17'b0, b[3:0]};
                    cont_left = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    gathered  = {18'b0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    bad  = 1'b1;
                    emit = 1'b1;
                end
            end else begin
                if (b[7:6] != 2'b10) begin
                    bad       = 1'b1;
                    emit      = 1'b1;
                    cont_left = 2'd0;
                    gathered  = '0;
                end else begin
                    gathered  = {gathered[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        cp       = gathered;
                        gathered = '0;
                        emit     = 1'b1;
                    end
                end
            end
            // buffer ends inside a sequence
            if (last && !emit) begin
                bad  = 1'b1;
                emit = 1'b1;
            end
            if (bad) begin
                cp        = ReplacementChar;
                buf_error = 1'b1;
            end
            if (emit) begin
                d.code_point = cp;
                d.bad        = bad;
                d.fin        = last;
                d.ok         = last && !buf_error;
                awaited_points.push_back(d);
            end
            if (last) begin
                buffers_seen++;
                cont_left = '0;
                gathered  = '0;
                buf_error = 1'b0;
            end
        endfunction

        function void match_code_point(logic [23:0] tdata, logic [1:0] tuser, logic tlast);
            decoded_t d;
            points_seen++;
            if (tuser[0])
                bad_seen++;
            if (awaited_points.size() == 0) begin
                $error("unexpected result: code_point %h bad %b final %b ok %b",
                       tdata[20:0], tuser[0], tlast, tuser[1]);
                mismatches++;
                return;
            end
            d = awaited_points.pop_front();
            if (tdata[20:0] !== d.code_point) begin
                $error("code_point: expected %h, got %h", d.code_point, tdata[20:0]);
                mismatches++;
            end
            if (tdata[23:21] !== 3'b000) begin
                $error("tdata pad: expected %b, got %b", 3'b000, tdata[23:21]);
                mismatches++;
            end
            if (tuser[0] !== d.bad) begin
                $error("bad_sequence: expected %b, got %b", d.bad, tuser[0]);
                mismatches++;
            end
            if (tlast !== d.fin) begin
                $error("final_result: expected %b, got %b", d.fin, tlast);
                mismatches++;
            end
            if (tuser[1] !== d.ok) begin
                $error("buffer_ok: expected %b, got %b", d.ok, tuser[1]);
                mismatches++;
            end
        endfunction
    endclass

    localparam int IdleLimit   = 1000;
    localparam int TargetBytes = 1250;

    localparam logic [8:0] DirectedItems [26] = '{
        9'h000, 9'h17F,
        9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h080, 9'h0FF, 9'h0F8, 9'h141,
        9'h0C3, 9'h041, 9'h0E2, 9'h182,
        9'h1C3,
        9'h0E0, 9'h1C0
    };

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    utf8_decode_tracker tracker;
    int                 idle_cycles;
    bit                 burst_mode;

    utf8_stream_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(byte_t b, logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_buffer(byte_t bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // One random character: mostly well-formed sequences, some noise.
    task automatic add_char(ref byte_t bytes[$]);
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            bytes.push_back(byte_t'($urandom_range(0, 127)));
        end else if (kind < 70) begin
            n = $urandom_range(1, 3);
            case (n)
                1: bytes.push_back(byte_t'(8'hC0 | ($urandom & 8'h1F)));
                2: bytes.push_back(byte_t'(8'hE0 | ($urandom & 8'h0F)));
                default: bytes.push_back(byte_t'(8'hF0 | ($urandom & 8'h07)));
            endcase
            repeat (n) bytes.push_back(byte_t'(8'h80 | ($urandom & 8'h3F)));
        end else if (kind < 80) begin
            bytes.push_back(byte_t'($urandom_range(0, 255)));
        end else if (kind < 90) begin
            // broken sequence: too few continuations, then some other byte
            bytes.push_back(byte_t'(8'hE0 | ($urandom & 8'h17)));
            if ($urandom_range(0, 1))
                bytes.push_back(byte_t'(8'h80 | ($urandom & 8'h3F)));
            bytes.push_back(byte_t'(($urandom & 8'h3F) |
                                    ($urandom_range(0, 1) ? 8'hC0 : 8'h00)));
        end else begin
            bytes.push_back(byte_t'(8'h80 | ($urandom & 8'h3F)));
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            int unsigned stall;
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_axis_tready = 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_axis_tready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_code_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        while (idle_cycles < IdleLimit) @(posedge aclk);
        $display("timeout: %0d cycles with no item accepted", IdleLimit);
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        byte_t buf_bytes[$];
        int    n_chars;
        tracker       = new();
        burst_mode    = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DirectedItems[i])
            send_byte(DirectedItems[i][7:0], DirectedItems[i][8]);

        while (tracker.bytes_seen < TargetBytes) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            buf_bytes.delete();
            n_chars = $urandom_range(1, 12);
            repeat (n_chars) add_char(buf_bytes);
            if ($urandom_range(0, 9) == 0 && buf_bytes.size() > 1)
                repeat ($urandom_range(1, buf_bytes.size() - 1)) void'(buf_bytes.pop_back());
            send_buffer(buf_bytes);
        end
        burst_mode = 1'b0;
        @(negedge aclk);
        s_axis_tvalid = 1'b0;

        while (tracker.awaited_points.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d bytes in %0d buffers, %0d results (%0d replacements)",
                 tracker.bytes_seen, tracker.buffers_seen, tracker.points_seen,
                 tracker.bad_seen);
        if (tracker.mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
